/* hw/rtl/mcl_pkg.sv */
// ----------------------------------------------------------------------------
// mcl_pkg
// shared types, constants, microcode table and format lookup for the
// mip chain layout generator
// ----------------------------------------------------------------------------
package mcl_pkg;

    // level limits
    localparam int MAX_LEVELS = 16;
    localparam int RESULT_CAP = 16;
    localparam int LEVEL_CAP  = (MAX_LEVELS < RESULT_CAP) ? MAX_LEVELS : RESULT_CAP;

    // number of format codes with a table entry
    localparam int NUM_FORMATS = 21;

    typedef struct packed {
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic [4:0]  wanted_levels;
        logic [4:0]  pixel_format;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [3:0]  level_index;
        logic [15:0] level_width;
        logic [15:0] level_height;
        logic [19:0] line_stride;
        logic [35:0] level_bytes;
        logic [36:0] level_offset;
        logic [4:0]  level_count;
        logic [36:0] total_bytes;
        logic        last_record;
    } t_out_word;

    // status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_ARG = 1'b1;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SCAN,
        OP_COUNT,
        OP_PITCH,
        OP_SIZE,
        OP_EMIT,
        OP_ERR
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_ZERO_DIM,
        C_SCAN_MORE,
        C_OUT_BUSY,
        C_MORE_LEVELS
    } t_cond;

    typedef logic [3:0] t_upc;

    // program addresses
    localparam t_upc A_IDLE     = 4'd0;
    localparam t_upc A_CHECK    = 4'd1;
    localparam t_upc A_SCAN     = 4'd2;
    localparam t_upc A_COUNT    = 4'd3;
    localparam t_upc A_PITCH    = 4'd4;
    localparam t_upc A_SIZE     = 4'd5;
    localparam t_upc A_EMIT     = 4'd6;
    localparam t_upc A_LOOP     = 4'd7;
    localparam t_upc A_DONE     = 4'd8;
    localparam t_upc A_ERR      = 4'd9;
    localparam t_upc A_ERR_DONE = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
        logic  accept;
    } t_uword;

    // status back from the datapath to the sequencer
    typedef struct packed {
        logic zero_dim;
        logic scan_more;
        logic out_busy;
        logic more_levels;
    } t_flags;

    function automatic t_uword microcode(input t_upc upc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE, accept: 1'b0};
        case (upc)
            A_IDLE:     w = '{op: OP_LOAD,  cond: C_NO_INPUT,    target: A_IDLE,  accept: 1'b1};
            A_CHECK:    w = '{op: OP_NOP,   cond: C_ZERO_DIM,    target: A_ERR,   accept: 1'b0};
            A_SCAN:     w = '{op: OP_SCAN,  cond: C_SCAN_MORE,   target: A_SCAN,  accept: 1'b0};
            A_COUNT:    w = '{op: OP_COUNT, cond: C_NEXT,        target: A_IDLE,  accept: 1'b0};
            A_PITCH:    w = '{op: OP_PITCH, cond: C_NEXT,        target: A_IDLE,  accept: 1'b0};
            A_SIZE:     w = '{op: OP_SIZE,  cond: C_NEXT,        target: A_IDLE,  accept: 1'b0};
            A_EMIT:     w = '{op: OP_EMIT,  cond: C_OUT_BUSY,    target: A_EMIT,  accept: 1'b0};
            A_LOOP:     w = '{op: OP_NOP,   cond: C_MORE_LEVELS, target: A_PITCH, accept: 1'b0};
            A_DONE:     w = '{op: OP_NOP,   cond: C_ALWAYS,      target: A_IDLE,  accept: 1'b0};
            A_ERR:      w = '{op: OP_ERR,   cond: C_OUT_BUSY,    target: A_ERR,   accept: 1'b0};
            A_ERR_DONE: w = '{op: OP_NOP,   cond: C_ALWAYS,      target: A_IDLE,  accept: 1'b0};
            default:    w = '{op: OP_NOP,   cond: C_ALWAYS,      target: A_IDLE,  accept: 1'b0};
        endcase
        return w;
    endfunction

    // bytes per pixel by format code, unknown codes give 4
    function automatic logic [4:0] bytes_per_pixel(input logic [4:0] code);
        logic [4:0] b;
        b = 5'd4;
        if (code < 5'(NUM_FORMATS)) begin
            case (code)
                5'd0, 5'd1:                      b = 5'd1;
                5'd2, 5'd3, 5'd4:                b = 5'd2;
                5'd5:                            b = 5'd3;
                5'd15:                           b = 5'd16;
                5'd16, 5'd17, 5'd18, 5'd19, 5'd20: b = 5'd1;
                default:                         b = 5'd4;
            endcase
        end
        return b;
    endfunction

endpackage

/* hw/rtl/mcl_sequencer.sv */
// ----------------------------------------------------------------------------
// mcl_sequencer
// step counter over the microcode table with conditional jumps
// ----------------------------------------------------------------------------
module mcl_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mcl_pkg::t_flags i_flags,
    output mcl_pkg::t_uword o_uword
);

    mcl_pkg::t_upc   r_upc;
    mcl_pkg::t_upc   n_upc;
    mcl_pkg::t_uword uw;
    logic            take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mcl_pkg::A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        uw = mcl_pkg::microcode(r_upc);
        case (uw.cond)
            mcl_pkg::C_NEXT:        take = 1'b0;
            mcl_pkg::C_ALWAYS:      take = 1'b1;
            mcl_pkg::C_NO_INPUT:    take = !i_in_valid;
            mcl_pkg::C_ZERO_DIM:    take = i_flags.zero_dim;
            mcl_pkg::C_SCAN_MORE:   take = i_flags.scan_more;
            mcl_pkg::C_OUT_BUSY:    take = i_flags.out_busy;
            mcl_pkg::C_MORE_LEVELS: take = i_flags.more_levels;
            default:                take = 1'b1;
        endcase
        n_upc = take ? uw.target : r_upc + 4'd1;
    end

    assign o_uword = uw;

endmodule

/* hw/rtl/mcl_datapath.sv */
// ----------------------------------------------------------------------------
// mcl_datapath
// request registers, chain length scan, per level arithmetic and output word
// ----------------------------------------------------------------------------
module mcl_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcl_pkg::t_op       i_op,
    input  logic               i_in_valid,
    input  mcl_pkg::t_in_word  i_in_word,
    input  logic               i_out_stall,
    output mcl_pkg::t_flags    o_flags,
    output logic               o_out_valid,
    output mcl_pkg::t_out_word o_out_word
);

    logic [15:0] r_w, r_h, r_maxd, r_sw, r_sh, r_lw, r_lh;
    logic [4:0]  r_want, r_bpp, r_full, r_count, r_lvl;
    logic [19:0] r_pitch;
    logic [35:0] r_size;
    logic [36:0] r_off, r_cur;
    logic        r_out_valid;
    mcl_pkg::t_out_word r_out_word;

    logic        out_busy;
    logic        fire;
    logic [15:0] lw_c, lh_c;
    logic [20:0] pitch_sum;
    logic [36:0] cur_rnd, level_end;
    logic [4:0]  cnt_a, cnt_b;

    assign out_busy  = r_out_valid && i_out_stall;
    assign fire      = (i_op == mcl_pkg::OP_EMIT || i_op == mcl_pkg::OP_ERR) && !out_busy;
    assign lw_c      = (r_sw == 16'd0) ? 16'd1 : r_sw;
    assign lh_c      = (r_sh == 16'd0) ? 16'd1 : r_sh;
    assign pitch_sum = 21'(lw_c) * 21'(r_bpp) + 21'd15;
    assign cur_rnd   = r_cur + 37'd255;
    assign level_end = r_off + {1'b0, r_size};
    assign cnt_a     = (r_want == 5'd0 || r_want > r_full) ? r_full : r_want;
    assign cnt_b     = (cnt_a > 5'(mcl_pkg::LEVEL_CAP)) ? 5'(mcl_pkg::LEVEL_CAP) : cnt_a;

    always_ff @(posedge i_clk) begin
        case (i_op)
            mcl_pkg::OP_LOAD: begin
                if (i_in_valid) begin
                    r_w    <= i_in_word.tex_width;
                    r_h    <= i_in_word.tex_height;
                    r_sw   <= i_in_word.tex_width;
                    r_sh   <= i_in_word.tex_height;
                    r_want <= i_in_word.wanted_levels;
                    r_bpp  <= mcl_pkg::bytes_per_pixel(i_in_word.pixel_format);
                    r_maxd <= (i_in_word.tex_width > i_in_word.tex_height) ?
                              i_in_word.tex_width : i_in_word.tex_height;
                    r_full <= 5'd1;
                    r_lvl  <= 5'd0;
                    r_cur  <= 37'd0;
                end
            end
            mcl_pkg::OP_SCAN: begin
                if (r_maxd > 16'd1) begin
                    r_maxd <= r_maxd >> 1;
                    r_full <= r_full + 5'd1;
                end
            end
            mcl_pkg::OP_COUNT: r_count <= cnt_b;
            mcl_pkg::OP_PITCH: begin
                r_lw    <= lw_c;
                r_lh    <= lh_c;
                r_pitch <= {pitch_sum[19:4], 4'b0000};
                r_off   <= {cur_rnd[36:8], 8'h00};
            end
            mcl_pkg::OP_SIZE: r_size <= 36'(r_pitch) * 36'(r_lh);
            mcl_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    r_cur <= level_end;
                    r_lvl <= r_lvl + 5'd1;
                    r_sw  <= r_sw >> 1;
                    r_sh  <= r_sh >> 1;
                end
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (i_op == mcl_pkg::OP_ERR) begin
                r_out_word <= '{status:       mcl_pkg::ST_BAD_ARG,
                                level_index:  4'd0,
                                level_width:  16'd0,
                                level_height: 16'd0,
                                line_stride:  20'd0,
                                level_bytes:  36'd0,
                                level_offset: 37'd0,
                                level_count:  5'd0,
                                total_bytes:  37'd0,
                                last_record:  1'b1};
            end else begin
                r_out_word.status       <= mcl_pkg::ST_OK;
                r_out_word.level_index  <= r_lvl[3:0];
                r_out_word.level_width  <= r_lw;
                r_out_word.level_height <= r_lh;
                r_out_word.line_stride  <= r_pitch;
                r_out_word.level_bytes  <= r_size;
                r_out_word.level_offset <= r_off;
                if (r_lvl + 5'd1 == r_count) begin
                    r_out_word.level_count <= r_count;
                    r_out_word.total_bytes <= level_end;
                    r_out_word.last_record <= 1'b1;
                end else begin
                    r_out_word.level_count <= 5'd0;
                    r_out_word.total_bytes <= 37'd0;
                    r_out_word.last_record <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_flags.zero_dim    = (r_w == 16'd0) || (r_h == 16'd0);
    assign o_flags.scan_more   = r_maxd > 16'd1;
    assign o_flags.out_busy    = out_busy;
    assign o_flags.more_levels = r_lvl != r_count;
    assign o_out_valid         = r_out_valid;
    assign o_out_word          = r_out_word;

endmodule

/* hw/rtl/mip_chain_layout_generator_unit.sv */
// ----------------------------------------------------------------------------
// mip_chain_layout_generator_unit
// texture mip chain layout: one request in, one record word per mip level out
// ----------------------------------------------------------------------------
// first record: after accept the check, scan, count, pitch, size and emit
//   steps run in order; the scan shifts max(width,height) one bit per cycle
//   to find the chain length. a new request is taken only back in idle; each level takes
//   four microcode steps (pitch, multiply, emit, loop test), longer if stalled
// zero width or height: one error record, from the error step after the check
// reset: synchronous active low, clears the step counter and output valid
// ----------------------------------------------------------------------------
module mip_chain_layout_generator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mcl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mcl_pkg::t_out_word o_out_word
);

    // control word of the current step and status back from the datapath
    mcl_pkg::t_uword uword;
    mcl_pkg::t_flags flags;

    // sequencer: step counter walks the microcode table
    mcl_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_uword    (uword)
    );

    // datapath: request registers, scan, per level arithmetic, output register
    mcl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (uword.op),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // requests are taken only in the idle step of the program
    assign o_in_stall = !uword.accept;

`ifndef SYNTHESIS
    // an accepted request always moves the sequencer out of idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer still idle after accepting a request");

    // an error record is always the single, last record and carries no size
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status) |->
        (o_out_word.last_record && o_out_word.level_bytes == 36'd0))
        else $error("error record not flagged last or carries data");

    // alignment of pitch and offset on every record
    a_alignment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_out_word.line_stride[3:0] == 4'd0 && o_out_word.level_offset[7:0] == 8'd0))
        else $error("pitch or offset misaligned");

    // level count and total only on the last record
    a_totals_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last_record) |->
        (o_out_word.level_count == 5'd0 && o_out_word.total_bytes == 37'd0))
        else $error("totals present on a record that is not last");
`endif

endmodule
